>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the bit packer.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, disabled while reset is high.
`define PCBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Property checked on the rising clock edge, including cycles under reset.
`define PCBP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) \
      else $error(msg);

`endif

>>> sv/pcbp_pkg.sv
// Shared types, codes and default sizes of the prefix code bit packer.
// No dependencies; used by the interfaces, controller, datapath and checker.
package pcbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;
   localparam int TOTAL_WIDTH  = 32;

   localparam int MODE_W      = 2;
   localparam int SYMBOL_W    = 8;
   localparam int LENGTH_W    = 6;
   localparam int CODE_W      = 32;
   localparam int KIND_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int BIT_TOTAL_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic accept;
      logic load_wr;
      logic look;
      logic push_byte;
      logic push_err;
      logic push_pad;
      logic push_end;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     hit;
      logic     look_bytes;
      logic     byte_last;
      logic     has_pend;
      logic     out_free;
   } status_type;

endpackage

>>> sv/pcbp_channels_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on pcbp_pkg for the field widths.
interface pcbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [pcbp_pkg::MODE_W-1:0]      mode;
   logic [pcbp_pkg::SYMBOL_W-1:0]    symbol;
   logic [pcbp_pkg::LENGTH_W-1:0]    code_length;
   logic [pcbp_pkg::CODE_W-1:0]      code_value;

   modport source (output valid, mode, symbol, code_length, code_value, input ready);
   modport sink (input valid, mode, symbol, code_length, code_value, output ready);
endinterface

interface pcbp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pcbp_pkg::KIND_W-1:0]      kind;
   logic [pcbp_pkg::BYTE_W-1:0]      out_byte;
   logic [pcbp_pkg::BIT_TOTAL_W-1:0] bit_total;
   logic                             last;

   modport source (output valid, kind, out_byte, bit_total, last, input ready);
   modport sink (input valid, kind, out_byte, bit_total, last, output ready);
endinterface

>>> sv/pcbp_ctrl.sv
// Controller state machine of the bit packer: sequences load, encode and flush.
// Depends on pcbp_pkg for the command and status structs.
module pcbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pcbp_pkg::status_type status,
   output pcbp_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOOK  = 6'b000010,
      ST_EMIT  = 6'b000100,
      ST_ERR   = 6'b001000,
      ST_FLUSH = 6'b010000,
      ST_END   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (status.mode)
                  pcbp_pkg::MODE_LOAD:   cmd.load_wr = 1'b1;
                  pcbp_pkg::MODE_ENCODE: state_in = ST_LOOK;
                  pcbp_pkg::MODE_FLUSH:  state_in = ST_FLUSH;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOK: begin
            if (!status.hit) begin
               state_in = ST_ERR;
            end else begin
               cmd.look = 1'b1;
               state_in = status.look_bytes ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.push_byte = 1'b1;
               if (status.byte_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.push_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!status.has_pend) begin
               state_in = ST_END;
            end else if (status.out_free) begin
               cmd.push_pad = 1'b1;
               state_in     = ST_END;
            end
         end
         ST_END: begin
            if (status.out_free) begin
               cmd.push_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/pcbp_datapath.sv
// Datapath of the bit packer: code table memory, bit shift register, counters
// and the response register. Depends on pcbp_pkg; driven by pcbp_ctrl.
module pcbp_datapath #(
   parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT,
   parameter int TOTAL_WIDTH  = pcbp_pkg::TOTAL_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pcbp_pkg::cmd_type                cmd,
   output pcbp_pkg::status_type             status,
   input  logic [pcbp_pkg::MODE_W-1:0]      req_mode,
   input  logic [pcbp_pkg::SYMBOL_W-1:0]    req_symbol,
   input  logic [pcbp_pkg::LENGTH_W-1:0]    req_code_length,
   input  logic [pcbp_pkg::CODE_W-1:0]      req_code_value,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [pcbp_pkg::KIND_W-1:0]      rsp_kind,
   output logic [pcbp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [pcbp_pkg::BIT_TOTAL_W-1:0] rsp_bit_total,
   output logic                             rsp_last
);

   localparam int LW    = $clog2(MAX_CODE_LEN + 1);
   localparam int W     = MAX_CODE_LEN + 8;
   localparam int CW    = $clog2(W);
   localparam int AW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int MEM_W = LW + MAX_CODE_LEN;

   logic [MEM_W-1:0]        mem [SYMBOL_COUNT];
   logic [MEM_W-1:0]        rd_ff;
   logic [SYMBOL_COUNT-1:0] entry_valid_ff;
   logic                    hit_ff;
   logic [W-1:0]            sr_ff, sr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [TOTAL_WIDTH-1:0]  bits_ff, bits_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   pcbp_pkg::kind_type      kind_ff, kind_in;
   logic [7:0]              byte_ff, byte_in;
   logic [TOTAL_WIDTH-1:0]  total_ff, total_in;
   logic                    last_ff, last_in;

   logic [AW-1:0]           idx;
   logic                    in_range;
   logic [LW-1:0]           len_sat;
   logic [LW-1:0]           align_shift;
   logic [MAX_CODE_LEN-1:0] code_la;
   logic [LW-1:0]           rd_len;
   logic [MAX_CODE_LEN-1:0] rd_code;
   logic [W-1:0]            sr_look;
   logic [CW-1:0]           cnt_look;
   logic [CW-1:0]           cnt_minus8;
   logic                    push_any;

   assign idx         = req_symbol[AW-1:0];
   assign in_range    = {1'b0, req_symbol} < 9'(SYMBOL_COUNT);
   assign len_sat     = (req_code_length > 6'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                             : LW'(req_code_length);
   assign align_shift = LW'(MAX_CODE_LEN) - len_sat;
   assign code_la     = MAX_CODE_LEN'(req_code_value) << align_shift;

   assign rd_len     = rd_ff[MEM_W-1 -: LW];
   assign rd_code    = rd_ff[MAX_CODE_LEN-1:0];
   assign sr_look    = sr_ff | ({rd_code, 8'b0} >> cnt_ff);
   assign cnt_look   = cnt_ff + CW'(rd_len);
   assign cnt_minus8 = cnt_ff - CW'(8);

   always_ff @(posedge clock) begin
      if (cmd.accept && cmd.load_wr && in_range) begin
         mem[idx] <= {len_sat, code_la};
      end
      if (cmd.accept) begin
         rd_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         hit_ff         <= 1'b0;
      end else if (cmd.accept) begin
         hit_ff <= in_range && entry_valid_ff[idx];
         if (cmd.load_wr && in_range) begin
            entry_valid_ff[idx] <= 1'b1;
         end
      end
   end

   always_comb begin
      sr_in   = sr_ff;
      cnt_in  = cnt_ff;
      bits_in = bits_ff;
      if (cmd.look) begin
         sr_in   = sr_look;
         cnt_in  = cnt_look;
         bits_in = bits_ff + TOTAL_WIDTH'(rd_len);
      end else if (cmd.push_byte) begin
         sr_in  = sr_ff << 8;
         cnt_in = cnt_minus8;
      end else if (cmd.push_pad) begin
         sr_in   = '0;
         cnt_in  = '0;
         bits_in = bits_ff + TOTAL_WIDTH'(CW'(8) - cnt_ff);
      end else if (cmd.push_end) begin
         bits_in = '0;
      end
   end

   assign push_any = cmd.push_byte | cmd.push_err | cmd.push_pad | cmd.push_end;

   always_comb begin
      rsp_valid_in = push_any | (rsp_valid_ff & ~rsp_ready);
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      if (cmd.push_byte || cmd.push_pad) begin
         kind_in  = pcbp_pkg::KIND_DATA;
         byte_in  = sr_ff[W-1 -: 8];
         total_in = '0;
         last_in  = cmd.push_byte && (cnt_minus8 < CW'(8));
      end else if (cmd.push_err) begin
         kind_in  = pcbp_pkg::KIND_ERROR;
         byte_in  = '0;
         total_in = '0;
         last_in  = 1'b1;
      end else if (cmd.push_end) begin
         kind_in  = pcbp_pkg::KIND_END;
         byte_in  = '0;
         total_in = bits_ff;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff        <= '0;
         cnt_ff       <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sr_ff        <= sr_in;
         cnt_ff       <= cnt_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      total_ff <= total_in;
      last_ff  <= last_in;
   end

   assign status.mode       = pcbp_pkg::mode_type'(req_mode);
   assign status.hit        = hit_ff;
   assign status.look_bytes = cnt_look >= CW'(8);
   assign status.byte_last  = cnt_minus8 < CW'(8);
   assign status.has_pend   = cnt_ff != '0;
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_bit_total = 32'(total_ff);
   assign rsp_last      = last_ff;

endmodule

>>> sv/prefix_code_bit_packer_unit.sv
// Top level of the prefix code bit packer: controller plus datapath.
// Depends on pcbp_pkg, pcbp_req_if, pcbp_rsp_if, pcbp_ctrl and pcbp_datapath.
//
//   Channel   Direction  Transaction
//   req_chan  in         load entry, encode symbol or flush stream
//   rsp_chan  out        data byte, end marker or unknown symbol error
//
// A load writes its table entry when the request is accepted. An encode reads the table,
// merges the code into the bit register, then emits each full output byte (up to four).
// An unknown symbol gives an error response; a flush emits a padded byte if bits are pending, then the end marker.
// A response stall holds the controller in its output state; the response register
// lets the next request enter while the last response of a transaction waits.
// Reset is synchronous; it clears the table valid bits at once, so no sweep.
module prefix_code_bit_packer_unit #(
   parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT,
   parameter int TOTAL_WIDTH  = pcbp_pkg::TOTAL_WIDTH
) (
   input logic        clock,
   input logic        reset,
   pcbp_req_if.sink   req_chan,
   pcbp_rsp_if.source rsp_chan
);

   pcbp_pkg::cmd_type    cmd;
   pcbp_pkg::status_type status;

   pcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcbp_datapath #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .TOTAL_WIDTH  (TOTAL_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_chan.mode),
      .req_symbol      (req_chan.symbol),
      .req_code_length (req_chan.code_length),
      .req_code_value  (req_chan.code_value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_kind        (rsp_chan.kind),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_bit_total   (rsp_chan.bit_total),
      .rsp_last        (rsp_chan.last)
   );

endmodule

>>> sv/pcbp_checker.sv
// Port-level checks on the response channel of the bit packer, bound to the top.
// Depends on pcbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcbp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pcbp_pkg::KIND_W-1:0]      rsp_kind,
   input logic [pcbp_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic [pcbp_pkg::BIT_TOTAL_W-1:0] rsp_bit_total,
   input logic                             rsp_last
);

   `PCBP_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_valid, "response valid after reset")
   `PCBP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_bit_total) && $stable(rsp_last), "stalled response changed")
   `PCBP_ASSERT(a_err_shape, clock, reset, rsp_valid && rsp_kind == pcbp_pkg::KIND_ERROR |-> rsp_last && rsp_out_byte == '0 && rsp_bit_total == '0, "malformed error response")
   `PCBP_ASSERT(a_end_shape, clock, reset, rsp_valid && rsp_kind == pcbp_pkg::KIND_END |-> rsp_last && rsp_out_byte == '0, "malformed end marker")

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_bit_total (rsp_chan.bit_total),
   .rsp_last      (rsp_chan.last)
);

>>> tb/pcbp_result_checker.sv
// Checker for the prefix code bit packer: watches both channels, predicts the output
// transactions of every accepted request and compares them in order.
// Depends on pcbp_pkg and on the pcbp_req_if and pcbp_rsp_if interfaces.
module pcbp_result_checker (
   input  logic clock,
   input  logic reset,
   pcbp_req_if  req_mon,
   pcbp_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outputs_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      pcbp_pkg::kind_type                     kind;
      logic [pcbp_pkg::BYTE_W-1:0]            out_byte;
      logic [pcbp_pkg::BIT_TOTAL_W-1:0]       bit_total;
      logic                                   last;
   } packer_output_type;

   packer_output_type                    awaited_q[$];
   logic [pcbp_pkg::LENGTH_W-1:0]        code_len_tab [256];
   logic [pcbp_pkg::CODE_W-1:0]          code_bits_tab [256];
   logic                                 code_loaded [256];
   logic [6:0]                           held_bits;
   int                                   held_count;
   logic [pcbp_pkg::TOTAL_WIDTH-1:0]     stream_total;
   int                                   bad_outputs;

   function automatic void queue_output(pcbp_pkg::kind_type k,
                                        logic [pcbp_pkg::BYTE_W-1:0] b,
                                        logic [pcbp_pkg::BIT_TOTAL_W-1:0] t, logic l);
      packer_output_type item;
      item.kind      = k;
      item.out_byte  = b;
      item.bit_total = t;
      item.last      = l;
      awaited_q.insert(awaited_q.size(), item);
   endfunction

   task automatic pack_request(logic [pcbp_pkg::MODE_W-1:0] mode_raw,
                               logic [pcbp_pkg::SYMBOL_W-1:0] sym,
                               logic [pcbp_pkg::LENGTH_W-1:0] len_in,
                               logic [pcbp_pkg::CODE_W-1:0] code_in);
      logic [63:0] acc;
      int          cnt;
      int          len;
      int          pad;
      case (pcbp_pkg::mode_type'(mode_raw))
         pcbp_pkg::MODE_LOAD: begin
            if (int'(sym) < pcbp_pkg::SYMBOL_COUNT) begin
               len = (int'(len_in) > pcbp_pkg::MAX_CODE_LEN) ? pcbp_pkg::MAX_CODE_LEN
                                                             : int'(len_in);
               code_len_tab[sym]  = pcbp_pkg::LENGTH_W'(len);
               code_bits_tab[sym] = pcbp_pkg::CODE_W'(64'(code_in) &
                                                      ((64'd1 << len) - 64'd1));
               code_loaded[sym]   = 1'b1;
            end
         end
         pcbp_pkg::MODE_ENCODE: begin
            if (int'(sym) >= pcbp_pkg::SYMBOL_COUNT || !code_loaded[sym]) begin
               queue_output(pcbp_pkg::KIND_ERROR, '0, '0, 1'b1);
            end else begin
               len = int'(code_len_tab[sym]);
               acc = (64'(held_bits) << len) | 64'(code_bits_tab[sym]);
               cnt = held_count + len;
               while (cnt >= 8) begin
                  queue_output(pcbp_pkg::KIND_DATA, pcbp_pkg::BYTE_W'(acc >> (cnt - 8)),
                               '0, (cnt - 8) < 8);
                  cnt -= 8;
               end
               held_bits    = 7'(acc & ((64'd1 << cnt) - 64'd1));
               held_count   = cnt;
               stream_total = stream_total + pcbp_pkg::TOTAL_WIDTH'(len);
            end
         end
         pcbp_pkg::MODE_FLUSH: begin
            if (held_count > 0) begin
               pad = 8 - held_count;
               queue_output(pcbp_pkg::KIND_DATA,
                            pcbp_pkg::BYTE_W'({1'b0, held_bits} << pad), '0, 1'b0);
               stream_total = stream_total + pcbp_pkg::TOTAL_WIDTH'(pad);
            end
            queue_output(pcbp_pkg::KIND_END, '0, pcbp_pkg::BIT_TOTAL_W'(stream_total), 1'b1);
            held_bits    = '0;
            held_count   = 0;
            stream_total = '0;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      packer_output_type exp;
      if (reset) begin
         awaited_q.delete();
         foreach (code_loaded[i]) code_loaded[i] = 1'b0;
         held_bits    = '0;
         held_count   = 0;
         stream_total = '0;
         bad_outputs  = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            pack_request(req_mon.mode, req_mon.symbol, req_mon.code_length,
                         req_mon.code_value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_q.size() == 0) begin
               bad_outputs++;
               $display("%0t: unexpected transaction: kind %0d byte %02h total %0d last %0b",
                        $time, rsp_mon.kind, rsp_mon.out_byte, rsp_mon.bit_total,
                        rsp_mon.last);
            end else begin
               exp = awaited_q.pop_front();
               if (rsp_mon.kind !== exp.kind || rsp_mon.out_byte !== exp.out_byte ||
                   rsp_mon.bit_total !== exp.bit_total || rsp_mon.last !== exp.last) begin
                  bad_outputs++;
                  $display("%0t: mismatch: expected kind %0d byte %02h total %0d last %0b,",
                           $time, exp.kind, exp.out_byte, exp.bit_total, exp.last,
                           " actual kind %0d byte %02h total %0d last %0b",
                           rsp_mon.kind, rsp_mon.out_byte, rsp_mon.bit_total,
                           rsp_mon.last);
               end
            end
         end
      end
      mismatch_count  <= bad_outputs;
      outputs_awaited <= awaited_q.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the bit packer testbench: clock, reset, request stimulus with bursts and
// gaps, response stalls, and the verdict. Depends on pcbp_pkg, the channel
// interfaces, prefix_code_bit_packer_unit and pcbp_result_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset = 1'b1;
   int   mismatch_count;
   int   outputs_awaited;
   int   burst_left = 1;
   int   stall_style = 0;
   int   stall_span = 0;
   int   stall_hold = 0;
   bit   sym_loaded [256];
   logic [7:0] loaded_syms[$];

   pcbp_req_if req_chan();
   pcbp_rsp_if rsp_chan();

   prefix_code_bit_packer_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pcbp_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .outputs_awaited (outputs_awaited)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_span  = $urandom_range(16, 96);
      end
      stall_span--;
      case (stall_style)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_hold > 0) begin
               stall_hold--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_hold = $urandom_range(1, 8);
            end
         end
      endcase
   end

   task automatic issue(pcbp_pkg::mode_type m, logic [7:0] sym, logic [5:0] len,
                        logic [31:0] code);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= m;
      req_chan.symbol      <= sym;
      req_chan.code_length <= len;
      req_chan.code_value  <= code;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (m == pcbp_pkg::MODE_LOAD && !sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.insert(loaded_syms.size(), sym);
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outputs_awaited != 0);
   endtask

   initial begin
      int          pick;
      int          roll;
      logic [7:0]  sym;
      logic [5:0]  len;
      req_chan.valid       = 1'b0;
      req_chan.mode        = '0;
      req_chan.symbol      = '0;
      req_chan.code_length = '0;
      req_chan.code_value  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      issue(pcbp_pkg::MODE_ENCODE, 8'd5, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_FLUSH, 8'd0, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd0, 6'd0, 32'hFFFF_FFFF);
      issue(pcbp_pkg::MODE_ENCODE, 8'd0, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd255, 6'd63, 32'hFFFF_FFFF);
      issue(pcbp_pkg::MODE_LOAD, 8'd1, 6'd3, 32'hFFFF_FFF5);
      issue(pcbp_pkg::MODE_ENCODE, 8'd1, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_ENCODE, 8'd255, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd2, 6'd32, 32'h0000_0000);
      issue(pcbp_pkg::MODE_ENCODE, 8'd2, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_NONE, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
      issue(pcbp_pkg::MODE_LOAD, 8'd128, 6'd33, 32'h8000_0001);
      issue(pcbp_pkg::MODE_ENCODE, 8'd128, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd3, 6'd1, 32'h0000_0001);
      issue(pcbp_pkg::MODE_ENCODE, 8'd3, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_FLUSH, 8'd0, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd170, 6'd8, 32'h0000_00A5);
      issue(pcbp_pkg::MODE_ENCODE, 8'd170, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_FLUSH, 8'd0, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_ENCODE, 8'd85, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_LOAD, 8'd4, 6'd7, 32'h0000_0055);
      issue(pcbp_pkg::MODE_ENCODE, 8'd4, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_ENCODE, 8'd255, 6'd0, 32'd0);
      issue(pcbp_pkg::MODE_FLUSH, 8'd0, 6'd0, 32'd0);
      drain();

      for (int i = 0; i < 400; i++) begin
         pick = $urandom_range(0, 99);
         if (loaded_syms.size() < 8 || pick < 18) begin
            sym  = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 5)
               len = 6'd0;
            else if (roll < 80)
               len = 6'($urandom_range(1, 12));
            else if (roll < 92)
               len = 6'($urandom_range(13, 32));
            else
               len = 6'($urandom_range(33, 63));
            issue(pcbp_pkg::MODE_LOAD, sym, len, 32'($urandom));
         end else if (pick < 88) begin
            if ($urandom_range(0, 9) == 0)
               sym = 8'($urandom_range(0, 255));
            else
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            issue(pcbp_pkg::MODE_ENCODE, sym, 6'($urandom), 32'($urandom));
         end else if (pick < 97) begin
            issue(pcbp_pkg::MODE_FLUSH, 8'($urandom), 6'($urandom), 32'($urandom));
         end else begin
            issue(pcbp_pkg::MODE_NONE, 8'($urandom), 6'($urandom), 32'($urandom));
         end
         if (i % 150 == 149 || $urandom_range(0, 59) == 0) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outputs_awaited == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/pcbp_pkg.sv
sv/pcbp_channels_if.sv
sv/pcbp_ctrl.sv
sv/pcbp_datapath.sv
sv/prefix_code_bit_packer_unit.sv
sv/pcbp_checker.sv
tb/pcbp_result_checker.sv
tb/tb_top.sv
